[rtl/npcm_pkg.sv]
// shared constants and types of the nearest palette colour mapper
package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int CH_W          = 8;
  localparam int COLOR_W       = 3 * CH_W;
  localparam int SQ_W          = 2 * CH_W;
  localparam int DIST_W        = 18;
  localparam int CFG_W         = 9;
  localparam int ENTRY_W       = 8;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_MAP   = 1'b1
  } action_e;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    pixel_t            pixel;
  } search_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic              empty;
  } search_res_t;

endpackage

[rtl/npcm_if.sv]
// valid/ready channel interfaces for input items and result items
interface npcm_in_if;
  import npcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [ENTRY_W-1:0] entry_index;
  logic [CH_W-1:0]    blue;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    red;

  modport source (output valid, action, entry_index, blue, green, red, input ready);
  modport sink   (input valid, action, entry_index, blue, green, red, output ready);
endinterface

interface npcm_out_if;
  import npcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] color_index;
  logic [DIST_W-1:0]  distance;
  logic               palette_empty;

  modport source (output valid, color_index, distance, palette_empty, input ready);
  modport sink   (input valid, color_index, distance, palette_empty, output ready);
endinterface

[rtl/npcm_palette_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
module npcm_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/npcm_search.sv]
// palette scan: address sequencer, squared distance pipe and best-match tracking
module npcm_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  npcm_pkg::search_req_t           req_i,
  input  logic                            res_ack_i,
  output npcm_pkg::search_res_t           res_o,
  output logic                            rd_en_o,
  output logic [npcm_pkg::IDX_W-1:0]      rd_addr_o,
  input  logic [npcm_pkg::COLOR_W-1:0]    rd_data_i
);
  import npcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  issue_q;
  logic              v1_q, v2_q;
  logic              first_q;
  logic              empty_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;

  logic [CNT_W-1:0]  cnt_q;
  pixel_t            pix_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q;
  logic [SQ_W-1:0]   sq_b_q, sq_g_q, sq_r_q;

  pixel_t            entry;
  logic [CH_W-1:0]   db, dg, dr;
  logic [DIST_W-1:0] sum;
  logic              take;
  logic              drained;

  function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign rd_en_o   = (state_q == S_SCAN) && (issue_q < cnt_q);
  assign rd_addr_o = issue_q[IDX_W-1:0];

  assign entry = pixel_t'(rd_data_i);
  assign db    = abs_diff(pix_q.blue,  entry.blue);
  assign dg    = abs_diff(pix_q.green, entry.green);
  assign dr    = abs_diff(pix_q.red,   entry.red);

  assign sum     = DIST_W'(sq_b_q) + DIST_W'(sq_g_q) + DIST_W'(sq_r_q);
  // strictly smaller only, so ties keep the lower index
  assign take    = v2_q && (first_q || (sum < best_dist_q));
  assign drained = (issue_q == cnt_q) && !v1_q && !v2_q;

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cnt_q <= req_i.count;
      pix_q <= req_i.pixel;
    end
    idx1_q <= rd_addr_o;
    idx2_q <= idx1_q;
    sq_b_q <= SQ_W'(db) * SQ_W'(db);
    sq_g_q <= SQ_W'(dg) * SQ_W'(dg);
    sq_r_q <= SQ_W'(dr) * SQ_W'(dr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      first_q     <= 1'b0;
      empty_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else begin
      v1_q <= rd_en_o;
      v2_q <= v1_q;
      if (rd_en_o) begin
        issue_q <= issue_q + 1'b1;
      end
      if (take) begin
        best_idx_q  <= idx2_q;
        best_dist_q <= sum;
        first_q     <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            issue_q     <= '0;
            first_q     <= 1'b1;
            best_idx_q  <= '0;
            best_dist_q <= '0;
            empty_q     <= (req_i.count == '0);
            state_q     <= (req_i.count == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (drained) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.busy     = (state_q != S_IDLE);
  assign res_o.done     = (state_q == S_DONE);
  assign res_o.idx      = best_idx_q;
  assign res_o.distance = best_dist_q;
  assign res_o.empty    = empty_q;

`ifndef NO_ASSERTIONS
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("distance stage valid without a preceding read");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= cnt_q))
    else $error("scan address ran past the palette count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && empty_q) |-> (best_idx_q == '0 && best_dist_q == '0))
    else $error("empty palette result carries non-zero index or distance");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && !empty_q) |-> (CNT_W'(best_idx_q) < cnt_q))
    else $error("chosen index lies outside the searched entries");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> (!rd_en_o && !v1_q && !v2_q))
    else $error("result shown while the scan pipe still holds work");
`endif

endmodule

[rtl/nearest_palette_color_mapper.sv]
// Nearest palette colour mapper. A write item (action 0) stores one blue-green-red entry
// in the palette ram and gives no result; a slot at or above the palette depth is
// ignored. A map item (action 1) scans entries 0 to count-1, one ram read per cycle, and
// returns the lowest index with the least squared distance together with that distance;
// the scan is paced by the single read port of the palette ram, whose registered read
// feeds the squaring registers and then the best-match registers. An empty palette
// answers with palette_empty set and index and distance zero. The input is not ready
// while a scan runs or its result waits in the search unit; once the result has moved to
// the output register the next item is taken even if that result is still unclaimed.
// palette_count above the depth is taken as the depth, and should be written only while
// the block is idle. Palette entries are not cleared at reset.
module nearest_palette_color_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [npcm_pkg::CFG_W-1:0]   cfg_wdata_i,
  npcm_in_if.sink                      in_i,
  npcm_out_if.source                   out_o
);
  import npcm_pkg::*;

  localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(PALETTE_DEPTH);

  logic [CFG_W-1:0]   count_q;
  logic [CFG_W-1:0]   count_sat;
  logic               accept;
  logic               ram_we;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [COLOR_W-1:0] rd_data;
  pixel_t             in_pix;
  search_req_t        req;
  search_res_t        res;
  logic               res_ack;

  logic               out_valid_q;
  logic [ENTRY_W-1:0] color_q;
  logic [DIST_W-1:0]  dist_q;
  logic               empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign count_sat = (count_q > DEPTH_CFG) ? DEPTH_CFG : count_q;

  // no transfer while scanning, so ram writes never meet scan reads
  assign in_i.ready = !res.busy;
  assign accept     = in_i.valid && in_i.ready;

  assign in_pix.blue  = in_i.blue;
  assign in_pix.green = in_i.green;
  assign in_pix.red   = in_i.red;

  assign ram_we = accept && (action_e'(in_i.action) == ACT_WRITE) &&
                  ({1'b0, in_i.entry_index} < DEPTH_CFG);

  assign req.start = accept && (action_e'(in_i.action) == ACT_MAP);
  assign req.count = count_sat[CNT_W-1:0];
  assign req.pixel = in_pix;

  npcm_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH (COLOR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.entry_index[IDX_W-1:0]),
    .wdata_i (in_pix),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  npcm_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .res_ack_i (res_ack),
    .res_o     (res),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  assign res_ack = res.done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      color_q <= ENTRY_W'(res.idx);
      dist_q  <= res.distance;
      empty_q <= res.empty;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.color_index   = color_q;
  assign out_o.distance      = dist_q;
  assign out_o.palette_empty = empty_q;

endmodule

[tb/tb.sv]
// testbench for nearest_palette_color_mapper: palette writes and pixel lookups
`timescale 1ns / 1ps

module tb;
  import npcm_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYC  = 16;
  localparam int DRAIN_CYC   = 300;

  typedef struct {
    action_e            action;
    logic [ENTRY_W-1:0] slot;
    pixel_t             px;
    bit                 drain;
  } pixel_item_t;

  typedef struct {
    logic [ENTRY_W-1:0] color_index;
    logic [DIST_W-1:0]  distance;
    logic               palette_empty;
  } match_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  npcm_in_if  pixel_ch ();
  npcm_out_if match_ch ();

  nearest_palette_color_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (pixel_ch),
    .out_o       (match_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state; the palette copy is updated on accepted transfers
  pixel_t           palette_copy [PALETTE_DEPTH];
  logic [CFG_W-1:0] count_copy;

  // stimulus-side view of the palette, so no unwritten entry is ever searched
  pixel_t gen_pal [PALETTE_DEPTH];
  bit     written_gen [PALETTE_DEPTH];

  pixel_item_t pixel_queue [$];
  match_t      match_queue [$];

  int unsigned send_gap_pct;
  int unsigned ready_stall_pct;
  int unsigned item_total;
  int unsigned fail_count;
  int unsigned cycle_count;
  logic        in_fire;

  function automatic int unsigned chan_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic match_t nearest_entry(pixel_t px);
    match_t      m;
    int unsigned span;
    int unsigned d;
    int unsigned best;
    span = (count_copy > PALETTE_DEPTH) ? PALETTE_DEPTH : count_copy;
    m.color_index   = '0;
    m.palette_empty = (span == 0);
    best = 0;
    for (int k = 0; k < span; k++) begin
      d = chan_sq(px.blue, palette_copy[k].blue) + chan_sq(px.green, palette_copy[k].green)
          + chan_sq(px.red, palette_copy[k].red);
      // strict compare keeps the lowest index on a tie
      if (k == 0 || d < best) begin
        best = d;
        m.color_index = k[ENTRY_W-1:0];
      end
    end
    m.distance = best[DIST_W-1:0];
    return m;
  endfunction

  function automatic pixel_t bgr(int unsigned b, int unsigned g, int unsigned r);
    pixel_t px;
    px.blue  = b[CH_W-1:0];
    px.green = g[CH_W-1:0];
    px.red   = r[CH_W-1:0];
    return px;
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return CH_W'($urandom_range(255));
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.blue  = rand_chan();
    px.green = rand_chan();
    px.red   = rand_chan();
    return px;
  endfunction

  task automatic push_write(int unsigned slot, pixel_t px);
    pixel_item_t it;
    it.action = ACT_WRITE;
    it.slot   = slot[ENTRY_W-1:0];
    it.px     = px;
    it.drain  = 1'b0;
    gen_pal[slot]     = px;
    written_gen[slot] = 1'b1;
    pixel_queue.push_back(it);
    item_total++;
  endtask

  task automatic push_map(pixel_t px, bit drain);
    pixel_item_t it;
    it.action = ACT_MAP;
    it.slot   = ENTRY_W'($urandom_range(255));
    it.px     = px;
    it.drain  = drain;
    pixel_queue.push_back(it);
    item_total++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pixel_queue.size() != 0 || pixel_ch.valid || match_queue.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_palette_count(logic [CFG_W-1:0] value);
    wait_idle();
    // writes give no result, so let any late write settle first
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    count_copy = value;
  endtask

  // driver: one item per transfer, changes on the falling edge
  always @(negedge clk_i) begin : driver
    pixel_item_t it;
    if (!rst_ni) begin
      pixel_ch.valid <= 1'b0;
    end else if (pixel_ch.valid && !in_fire) begin
      // hold the item until it is taken
    end else if (pixel_queue.size() != 0
                 && !(pixel_queue[0].drain && match_queue.size() != 0)
                 && $urandom_range(99) >= send_gap_pct) begin
      it = pixel_queue.pop_front();
      pixel_ch.valid       <= 1'b1;
      pixel_ch.action      <= it.action;
      pixel_ch.entry_index <= it.slot;
      pixel_ch.blue        <= it.px.blue;
      pixel_ch.green       <= it.px.green;
      pixel_ch.red         <= it.px.red;
    end else begin
      pixel_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    match_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // monitor: predicts on accepted items and checks accepted results
  always @(posedge clk_i) begin : monitor
    pixel_t px;
    match_t want;
    in_fire <= pixel_ch.valid && pixel_ch.ready;
    if (rst_ni && pixel_ch.valid && pixel_ch.ready) begin
      px = {pixel_ch.blue, pixel_ch.green, pixel_ch.red};
      if (pixel_ch.action == ACT_WRITE)
        palette_copy[pixel_ch.entry_index] = px;
      else
        match_queue.push_back(nearest_entry(px));
    end
    if (rst_ni && match_ch.valid && match_ch.ready) begin
      if (match_queue.size() == 0) begin
        $error("unexpected result: color_index %0d distance %0d palette_empty %0b",
               match_ch.color_index, match_ch.distance, match_ch.palette_empty);
        fail_count++;
      end else begin
        want = match_queue.pop_front();
        if (match_ch.color_index !== want.color_index) begin
          $error("color_index: expected %0d, got %0d", want.color_index, match_ch.color_index);
          fail_count++;
        end
        if (match_ch.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, match_ch.distance);
          fail_count++;
        end
        if (match_ch.palette_empty !== want.palette_empty) begin
          $error("palette_empty: expected %0b, got %0b", want.palette_empty,
                 match_ch.palette_empty);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_palette_color_mapper test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned wide_pick;
    int unsigned count;
    int unsigned span;
    int unsigned len;
    int unsigned slot;
    pixel_t      px;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.action      = ACT_WRITE;
    pixel_ch.entry_index = '0;
    pixel_ch.blue        = '0;
    pixel_ch.green       = '0;
    pixel_ch.red         = '0;
    match_ch.ready       = 1'b0;
    in_fire              = 1'b0;
    count_copy           = '0;
    send_gap_pct         = 20;
    ready_stall_pct      = 85;
    item_total           = 0;
    fail_count           = 0;
    cycle_count          = 0;
    foreach (written_gen[k]) written_gen[k] = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty palette straight after reset
    push_map(bgr(0, 0, 0), 1'b0);
    push_map(bgr(255, 255, 255), 1'b0);
    push_write(0, bgr(0, 0, 0));
    push_write(1, bgr(255, 255, 255));
    push_write(2, bgr(10, 20, 30));
    push_write(3, bgr(10, 20, 30));
    push_write(4, bgr(200, 0, 55));

    // single entry, largest possible distance
    set_palette_count(1);
    push_map(bgr(255, 255, 255), 1'b0);

    // entries 2 and 3 tie, the lower index must win
    set_palette_count(5);
    push_map(bgr(0, 0, 0), 1'b0);
    push_map(bgr(255, 255, 255), 1'b0);
    push_map(bgr(10, 20, 30), 1'b0);
    push_map(bgr(12, 19, 31), 1'b0);
    push_map(bgr(200, 0, 55), 1'b0);
    push_map(bgr(128, 128, 128), 1'b1);
    push_map(bgr(0, 255, 0), 1'b0);

    phase     = 0;
    wide_pick = 0;
    while (item_total < ITEM_TARGET) begin
      case (phase % 7)
        2: begin
          // full palette and counts past the depth, which saturate
          case (wide_pick)
            0:       count = 256;
            1:       count = 511;
            2:       count = 257;
            default: count = $urandom_range(255, 511);
          endcase
          wide_pick++;
          len = $urandom_range(12, 20);
        end
        5: begin
          count = 0;
          len   = $urandom_range(10, 20);
        end
        default: begin
          count = ($urandom_range(9) < 7) ? $urandom_range(1, 16) : $urandom_range(17, 64);
          len   = $urandom_range(20, 60);
        end
      endcase
      set_palette_count(CFG_W'(count));

      if (item_total < ITEM_TARGET / 3) begin
        send_gap_pct    = 20;
        ready_stall_pct = 85;
      end else if (item_total < 2 * ITEM_TARGET / 3) begin
        send_gap_pct    = 85;
        ready_stall_pct = 20;
      end else begin
        send_gap_pct    = 0;
        ready_stall_pct = 0;
      end

      span = (count > PALETTE_DEPTH) ? PALETTE_DEPTH : count;
      for (int k = 0; k < span; k++)
        if (!written_gen[k]) push_write(k, rand_pixel());

      repeat (len) begin
        if ($urandom_range(99) < 60) begin
          if (span != 0 && $urandom_range(99) < 35) begin
            // exact or near hit on a live entry
            px = gen_pal[$urandom_range(span - 1)];
            if ($urandom_range(1) == 1) px.green ^= 8'h01;
          end else begin
            px = rand_pixel();
          end
          push_map(px, $urandom_range(99) < 3);
        end else begin
          slot = (span != 0 && $urandom_range(1) == 1) ? $urandom_range(span - 1)
                                                       : $urandom_range(255);
          // duplicates of live entries give ties
          if (span != 0 && $urandom_range(4) == 0)
            px = gen_pal[$urandom_range(span - 1)];
          else
            px = rand_pixel();
          push_write(slot, px);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_count == 0)
      $display("nearest_palette_color_mapper test passed");
    else
      $display("nearest_palette_color_mapper test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/npcm_pkg.sv
rtl/npcm_if.sv
rtl/npcm_palette_ram.sv
rtl/npcm_search.sv
rtl/nearest_palette_color_mapper.sv
tb/tb.sv
